### rtl/core/isdiv_pkg.sv
// Shared constants and control types for the signed/unsigned integer divider.
package isdiv_pkg;

  // Fixed field widths of the channels
  localparam int DATA_W        = 64;
  localparam int MODE_W        = 2;
  localparam int NARROW_W      = 32;
  localparam int MAX_WIDTH_DEF = 64;

  // Operation modes
  localparam logic [MODE_W-1:0] MODE_U32 = 2'd0;
  localparam logic [MODE_W-1:0] MODE_S32 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_U64 = 2'd2;
  localparam logic [MODE_W-1:0] MODE_S64 = 2'd3;

  // Command from the sequencer to the shift-subtract unit
  typedef struct packed {
    logic start;
    logic wide;
  } isdiv_cmd_t;

  // Status back from the shift-subtract unit
  typedef struct packed {
    logic busy;
    logic done;
  } isdiv_sts_t;

endpackage

### rtl/core/isdiv_if.sv
// Valid/ready channel interfaces for divider operands and results.
interface isdiv_in_if;
  logic                            valid;
  logic                            ready;
  logic [isdiv_pkg::MODE_W-1:0]    mode;
  logic [isdiv_pkg::DATA_W-1:0]    dividend;
  logic [isdiv_pkg::DATA_W-1:0]    divisor;

  modport source (output valid, output mode, output dividend, output divisor, input ready);
  modport sink   (input valid, input mode, input dividend, input divisor, output ready);
endinterface

interface isdiv_out_if;
  logic                            valid;
  logic                            ready;
  logic [isdiv_pkg::DATA_W-1:0]    quotient;
  logic [isdiv_pkg::DATA_W-1:0]    remainder_out;
  logic                            divide_by_zero;

  modport source (output valid, output quotient, output remainder_out,
                  output divide_by_zero, input ready);
  modport sink   (input valid, input quotient, input remainder_out,
                  input divide_by_zero, output ready);
endinterface

### rtl/core/int_divider_signed_unsigned_unit.sv
// Integer divider, unsigned or signed, 32-bit or wide, restoring radix-2.
//
// Operands arrive on in_ch (mode, dividend, divisor) and results leave on
// out_ch (quotient, remainder_out, divide_by_zero), both valid/ready; a
// transfer happens on a clock edge with valid and ready high.
// One operation is in flight at a time. The shift-subtract unit retires one
// quotient bit per cycle; operand sign handling and unit load come before
// the iteration, completion and result sign fix-up after it. Divide by zero
// skips unit load and the iteration: sign handling leads straight to fix-up.
// The result sits in an output register. A finished result waits there while
// the receiver stalls, and the next operand is already taken in and worked on;
// the final fix-up then holds until the output register is free.
// Synchronous active-high reset empties the output register and returns the
// sequencer to idle; the operation under way and a result waiting in the
// output register are both lost.
module int_divider_signed_unsigned_unit #(
  parameter int MAX_WIDTH = isdiv_pkg::MAX_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  isdiv_in_if.sink      in_ch,
  isdiv_out_if.source   out_ch
);

  localparam int W  = MAX_WIDTH;
  localparam int NW = isdiv_pkg::NARROW_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_FIX   = 3'd4;

  logic [2:0]                   state;
  logic [2:0]                   state_next;

  logic [isdiv_pkg::MODE_W-1:0] mode_r;
  logic [W-1:0]                 dividend_r;
  logic [W-1:0]                 divisor_r;

  logic [W-1:0]                 a_reg;
  logic [W-1:0]                 b_reg;
  logic                         wide;
  logic                         sgn;
  logic                         neg_a;
  logic                         neg_b;
  logic                         dz;

  logic                         out_valid;
  logic [isdiv_pkg::DATA_W-1:0] quotient_r;
  logic [isdiv_pkg::DATA_W-1:0] remainder_r;
  logic                         dz_out;

  isdiv_pkg::isdiv_cmd_t        cmd;
  isdiv_pkg::isdiv_sts_t        sts;
  logic [W-1:0]                 core_q;
  logic [W-1:0]                 core_r;

  logic                         mode_wide;
  logic                         mode_sgn;
  logic [W-1:0]                 mask_prep;
  logic [W-1:0]                 a_m;
  logic [W-1:0]                 b_m;
  logic                         a_sign;
  logic                         b_sign;
  logic                         dz_prep;
  logic [W-1:0]                 mask_fix;
  logic [W-1:0]                 q_raw;
  logic [W-1:0]                 r_raw;
  logic [W-1:0]                 q_fin;
  logic [W-1:0]                 r_fin;
  logic                         out_free;

  function automatic logic [W-1:0] width_mask(input logic is_wide);
    width_mask = is_wide ? {W{1'b1}} : W'({NW{1'b1}});
  endfunction

  // Decode mode and condition the raw operands
  always_comb begin
    mode_wide = (mode_r == isdiv_pkg::MODE_U64) || (mode_r == isdiv_pkg::MODE_S64);
    mode_sgn  = (mode_r == isdiv_pkg::MODE_S32) || (mode_r == isdiv_pkg::MODE_S64);
    mask_prep = width_mask(mode_wide);
    a_m       = dividend_r & mask_prep;
    b_m       = divisor_r & mask_prep;
    a_sign    = mode_sgn & (mode_wide ? a_m[W-1] : a_m[NW-1]);
    b_sign    = mode_sgn & (mode_wide ? b_m[W-1] : b_m[NW-1]);
    dz_prep   = (b_m == '0);
  end

  // Apply result signs and width
  always_comb begin
    mask_fix = width_mask(wide);
    q_raw    = dz ? mask_fix : core_q;
    r_raw    = dz ? a_reg : core_r;
    q_fin    = ((sgn && (neg_a != neg_b) && !dz) ? (W'(0) - q_raw) : q_raw) & mask_fix;
    r_fin    = ((sgn && neg_a && !dz) ? (W'(0) - r_raw) : r_raw) & mask_fix;
    out_free = !out_valid || out_ch.ready;
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_ch.valid) state_next = S_PREP;
      S_PREP:  state_next = dz_prep ? S_FIX : S_START;
      S_START: state_next = S_RUN;
      S_RUN:   if (sts.done) state_next = S_FIX;
      S_FIX:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture operands on the input transfer
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      mode_r     <= in_ch.mode;
      dividend_r <= in_ch.dividend[W-1:0];
      divisor_r  <= in_ch.divisor[W-1:0];
    end
  end

  // Take magnitudes and note signs
  always_ff @(posedge clk) begin
    if (state == S_PREP) begin
      wide  <= mode_wide;
      sgn   <= mode_sgn;
      neg_a <= a_sign;
      neg_b <= b_sign;
      dz    <= dz_prep;
      a_reg <= (a_sign && !dz_prep) ? ((W'(0) - a_m) & mask_prep) : a_m;
      b_reg <= b_sign ? ((W'(0) - b_m) & mask_prep) : b_m;
    end
  end

  assign cmd.start = (state == S_START);
  assign cmd.wide  = wide;

  isdiv_shift_sub #(
    .W (W)
  ) u_shift_sub (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .num_in (a_reg),
    .den_in (b_reg),
    .sts    (sts),
    .quo    (core_q),
    .rem    (core_r)
  );

  // Output register: load on fix-up, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FIX) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FIX) && out_free) begin
      quotient_r  <= isdiv_pkg::DATA_W'(q_fin);
      remainder_r <= isdiv_pkg::DATA_W'(r_fin);
      dz_out      <= dz;
    end
  end

  assign in_ch.ready           = (state == S_IDLE) && !sts.busy;
  assign out_ch.valid          = out_valid;
  assign out_ch.quotient       = quotient_r;
  assign out_ch.remainder_out  = remainder_r;
  assign out_ch.divide_by_zero = dz_out;

endmodule

### rtl/core/isdiv_shift_sub.sv
// Radix-2 restoring shift-subtract unit: one quotient bit per cycle.
module isdiv_shift_sub #(
  parameter int W = isdiv_pkg::MAX_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  isdiv_pkg::isdiv_cmd_t cmd,
  input  logic [W-1:0]         num_in,
  input  logic [W-1:0]         den_in,
  output isdiv_pkg::isdiv_sts_t sts,
  output logic [W-1:0]         quo,
  output logic [W-1:0]         rem
);

  localparam int CW    = $clog2(W + 1);
  localparam int SHIFT = W - isdiv_pkg::NARROW_W;

  logic [W-1:0]  num_sr;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  den_r;
  logic [CW-1:0] cnt;
  logic          done;

  logic [W:0]    trial;
  logic [W+1:0]  diff;
  logic          fits;
  logic [W-1:0]  rem_next;
  logic [W-1:0]  num_next;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    trial    = {rem_r, num_sr[W-1]};
    diff     = {1'b0, trial} - {2'b00, den_r};
    fits     = ~diff[W+1];
    rem_next = fits ? diff[W-1:0] : trial[W-1:0];
    num_next = {num_sr[W-2:0], fits};
  end

  // Iteration counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (cmd.start) begin
      cnt  <= cmd.wide ? CW'(W) : CW'(isdiv_pkg::NARROW_W);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - CW'(1);
      done <= (cnt == CW'(1));
    end else begin
      done <= 1'b0;
    end
  end

  // Partial remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      num_sr <= cmd.wide ? num_in : (num_in << SHIFT);
      rem_r  <= '0;
      den_r  <= den_in;
    end else if (cnt != '0) begin
      num_sr <= num_next;
      rem_r  <= rem_next;
    end
  end

  assign sts.busy = (cnt != '0);
  assign sts.done = done;
  assign quo      = num_sr;
  assign rem      = rem_r;

endmodule

### rtl/core/isdiv_chk.sv
// Port-level checks for the integer divider, bound to the top level.
module isdiv_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [isdiv_pkg::DATA_W-1:0] quotient,
  input logic [isdiv_pkg::DATA_W-1:0] remainder_out,
  input logic                         divide_by_zero
);

  // A pending result holds until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(quotient) &&
      $stable(remainder_out) && $stable(divide_by_zero))
    else $error("result changed or dropped while stalled");

  // One operation at a time: busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while an operation is in flight");

  // Divide by zero always reports an all-ones low quotient
  a_dz_quot: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> (quotient[31:0] == 32'hFFFF_FFFF))
    else $error("divide by zero without all-ones quotient");

  // No result becomes valid at the input transfer itself when none was pending
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind int_divider_signed_unsigned_unit isdiv_chk u_isdiv_chk (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .quotient       (out_ch.quotient),
  .remainder_out  (out_ch.remainder_out),
  .divide_by_zero (out_ch.divide_by_zero)
);
